/* sv/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PUR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define PUR_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define PUR_ASSERT(lbl, clk, rst, prop)
`define PUR_NEVER(lbl, clk, rst, expr)
`endif
`endif

/* sv/pur_pkg.sv */
`default_nettype none
package pur_pkg;

  localparam int COORD_W   = 32;
  localparam int LEN_W     = 48;
  localparam int SEG_W     = 33;
  localparam int RAD_W     = 66;
  localparam int CNT_CFG_W = 6;
  localparam int PROD_W    = 65;
  localparam int DVS_W     = 33;

  // one stored vertex with its cumulative arc length
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [LEN_W-1:0]          c;
  } entry_t;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_SQ3,
    ST_RSTART,
    ST_ROOT,
    ST_FINAL,
    ST_DIVL,
    ST_RD0,
    ST_RD1,
    ST_SEEK,
    ST_FETCH,
    ST_MUL,
    ST_DIVI,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

/* sv/pur_mem.sv */
`default_nettype none
module pur_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire pur_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output pur_pkg::entry_t      rdata
);

  pur_pkg::entry_t mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/pur_div.sv */
`default_nettype none
module pur_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pur_pkg::PROD_W-1:0]  dividend,
  input  wire logic [pur_pkg::DVS_W-1:0]   divisor,
  output pur_pkg::unit_stat_t              stat,
  output logic [pur_pkg::PROD_W-1:0]       quot,
  output logic [pur_pkg::DVS_W-1:0]        rem
);

  localparam int CW = $clog2(pur_pkg::PROD_W + 1);

  logic [pur_pkg::PROD_W-1:0] dvd;
  logic [pur_pkg::DVS_W-1:0]  dvs;
  logic [pur_pkg::DVS_W-1:0]  r;
  logic [CW-1:0]              cnt;
  logic                       done;
  logic [pur_pkg::DVS_W:0]    r_sh;
  logic [pur_pkg::DVS_W:0]    r_sub;
  logic                       fit;

  // restoring step, one quotient bit per cycle
  assign r_sh  = {r, dvd[pur_pkg::PROD_W-1]};
  assign fit   = r_sh >= {1'b0, dvs};
  assign r_sub = r_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(pur_pkg::PROD_W);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      r   <= '0;
    end else if (cnt != '0) begin
      dvd <= {dvd[pur_pkg::PROD_W-2:0], fit};
      r   <= fit ? r_sub[pur_pkg::DVS_W-1:0] : r_sh[pur_pkg::DVS_W-1:0];
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;
  assign quot      = dvd;
  assign rem       = r;

endmodule
`default_nettype wire

/* sv/pur_sqrt.sv */
`default_nettype none
module pur_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [pur_pkg::RAD_W-1:0]  radicand,
  output pur_pkg::unit_stat_t             stat,
  output logic [pur_pkg::SEG_W-1:0]       root
);

  localparam int STEPS = pur_pkg::RAD_W / 2;
  localparam int CW    = $clog2(STEPS + 1);
  localparam int RW    = pur_pkg::SEG_W + 1;

  logic [pur_pkg::RAD_W-1:0] rad;
  logic [RW-1:0]             r;
  logic [CW-1:0]             cnt;
  logic                      done;
  logic [RW+1:0]             r_sh;
  logic [RW+1:0]             trial;
  logic [RW+1:0]             r_sub;
  logic                      fit;

  // digit recurrence, two radicand bits per cycle
  assign r_sh  = {r, rad[pur_pkg::RAD_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign fit   = r_sh >= trial;
  assign r_sub = r_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(STEPS);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      r    <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      rad  <= {rad[pur_pkg::RAD_W-3:0], 2'b00};
      r    <= fit ? r_sub[RW-1:0] : r_sh[RW-1:0];
      root <= {root[pur_pkg::SEG_W-2:0], fit};
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule
`default_nettype wire

/* sv/polyline_uniform_resampler.sv */
// Polyline uniform arc-length resampler.
// Input channel (in_valid/in_ready): one vertex per beat, point_x/y/z in
// signed Q15.16, final_vertex on the last one. The first vertex is stored in
// its accept cycle; every further vertex then goes through three squares
// on a shared 32x33 multiplier, then a 33-step square root, one bit pair a
// cycle. Vertices past MAX_VERTICES are dropped, their final flag still counts.
// After the final vertex the block emits segment_count+1 points on the output
// channel (out_valid/out_ready), run_end on the last. Setup is one 65-step
// division of the total length; each point then walks the stored
// vertices (a SEEK and a FETCH state per vertex passed, one memory read each)
// and for x, y, z does a multiply and, for a nonzero segment, a 65-step division.
// Fewer than two vertices give one beat with too_few_points and zeros.
// Input is taken only between runs; a stalled output beat holds the block.
// segment_count is to be written by the user through cfg_write_en/cfg_write_data
// while idle; the block does not enforce it. Zero acts as one. Reset empties the
// vertex count and sets segment_count to 1; the vertex memory needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module polyline_uniform_resampler #(
  parameter int MAX_VERTICES = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write_en,
  input  wire logic [pur_pkg::CNT_CFG_W-1:0]       cfg_write_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [pur_pkg::COORD_W-1:0]  point_x,
  input  wire logic signed [pur_pkg::COORD_W-1:0]  point_y,
  input  wire logic signed [pur_pkg::COORD_W-1:0]  point_z,
  input  wire logic                                final_vertex,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [pur_pkg::COORD_W-1:0]       out_x,
  output logic signed [pur_pkg::COORD_W-1:0]       out_y,
  output logic signed [pur_pkg::COORD_W-1:0]       out_z,
  output logic                                     run_end,
  output logic                                     too_few_points
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int CL = pur_pkg::COORD_W;
  localparam int LW = pur_pkg::LEN_W;
  localparam int SW = pur_pkg::SEG_W;
  localparam int NW = pur_pkg::CNT_CFG_W;

  pur_pkg::state_t state, state_next;

  logic [NW-1:0]              segment_count;
  logic [NW-1:0]              n_eff;
  logic [CW-1:0]              vcount;
  logic                       fin;
  logic signed [CL-1:0]       lx, ly, lz;
  logic signed [CL-1:0]       px, py, pz;
  logic [LW-1:0]              prev_c;
  logic [pur_pkg::RAD_W-1:0]  acc;
  logic [pur_pkg::PROD_W-1:0] mul_p;
  logic [CL-1:0]              mul_a;
  logic [SW-1:0]              mul_b;
  logic [LW-1:0]              step_q;
  logic [NW-1:0]              step_r;
  logic [LW-1:0]              t;
  logic [NW:0]                tr;
  logic [NW-1:0]              idx;
  logic [AW-1:0]              k;
  pur_pkg::entry_t            prv, cur;
  logic [SW-1:0]              num, den;
  logic [1:0]                 j;
  logic                       dneg;
  logic                       dneg_go;
  logic signed [CL-1:0]       pa, pb;
  logic signed [CL:0]         d;
  logic [CL-1:0]              dmag;
  logic [CL-1:0]              sq_mag;

  // memory and unit hookup
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  pur_pkg::entry_t            mem_wdata;
  logic [AW-1:0]              mem_raddr;
  pur_pkg::entry_t            mem_rdata;
  logic                       sq_start;
  pur_pkg::unit_stat_t        sq_stat;
  logic [SW-1:0]              sq_root;
  logic                       dv_start;
  logic [pur_pkg::PROD_W-1:0] dv_dividend;
  logic [pur_pkg::DVS_W-1:0]  dv_divisor;
  pur_pkg::unit_stat_t        dv_stat;
  logic [pur_pkg::PROD_W-1:0] dv_quot;
  logic [pur_pkg::DVS_W-1:0]  dv_rem;

  logic in_acc, out_acc, at_last;
  logic [NW:0] tr_sum;

  pur_mem #(.DEPTH(MAX_VERTICES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pur_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (acc),
    .stat     (sq_stat),
    .root     (sq_root)
  );

  pur_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_dividend),
    .divisor  (dv_divisor),
    .stat     (dv_stat),
    .quot     (dv_quot),
    .rem      (dv_rem)
  );

  assign n_eff   = (segment_count == '0) ? NW'(1) : segment_count;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign at_last = ({{(CW-AW){1'b0}}, k} == vcount - 1'b1);
  assign tr_sum  = tr + {1'b0, step_r};

  // coordinate selection for the current axis
  always_comb begin
    case (j)
      2'd0:    begin pa = prv.x; pb = cur.x; end
      2'd1:    begin pa = prv.y; pb = cur.y; end
      default: begin pa = prv.z; pb = cur.z; end
    endcase
    d    = {pb[CL-1], pb} - {pa[CL-1], pa};
    dmag = d[CL] ? CL'(-d) : d[CL-1:0];
  end

  // segment delta magnitude for the squaring steps
  always_comb begin
    case (state)
      pur_pkg::ST_SQ0: sq_mag = (lx >= px) ? CL'(lx - px) : CL'(px - lx);
      pur_pkg::ST_SQ1: sq_mag = (ly >= py) ? CL'(ly - py) : CL'(py - ly);
      default:         sq_mag = (lz >= pz) ? CL'(lz - pz) : CL'(pz - lz);
    endcase
  end

  // shared multiplier operands
  always_comb begin
    if (state == pur_pkg::ST_MUL) begin
      mul_a = dmag;
      mul_b = num;
    end else begin
      mul_a = sq_mag;
      mul_b = {1'b0, sq_mag};
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= {{(pur_pkg::PROD_W-CL){1'b0}}, mul_a} *
             {{(pur_pkg::PROD_W-SW){1'b0}}, mul_b};
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pur_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit control
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    sq_start    = 1'b0;
    dv_start    = 1'b0;
    dv_dividend = mul_p;
    dv_divisor  = den;
    mem_raddr   = '0;
    unique case (state)
      pur_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (vcount == CW'(MAX_VERTICES) || vcount == '0) begin
            state_next = final_vertex ? pur_pkg::ST_FINAL : pur_pkg::ST_LOAD;
          end else begin
            state_next = pur_pkg::ST_SQ0;
          end
        end
      end
      pur_pkg::ST_SQ0:    state_next = pur_pkg::ST_SQ1;
      pur_pkg::ST_SQ1:    state_next = pur_pkg::ST_SQ2;
      pur_pkg::ST_SQ2:    state_next = pur_pkg::ST_SQ3;
      pur_pkg::ST_SQ3:    state_next = pur_pkg::ST_RSTART;
      pur_pkg::ST_RSTART: begin
        sq_start   = 1'b1;
        state_next = pur_pkg::ST_ROOT;
      end
      pur_pkg::ST_ROOT: begin
        if (sq_stat.done) begin
          state_next = fin ? pur_pkg::ST_FINAL : pur_pkg::ST_LOAD;
        end
      end
      pur_pkg::ST_FINAL: begin
        if (vcount < CW'(2)) begin
          state_next = pur_pkg::ST_EMIT;
        end else begin
          dv_start    = 1'b1;
          dv_dividend = {{(pur_pkg::PROD_W-LW){1'b0}}, prev_c};
          dv_divisor  = {{(pur_pkg::DVS_W-NW){1'b0}}, n_eff};
          state_next  = pur_pkg::ST_DIVL;
        end
      end
      pur_pkg::ST_DIVL: begin
        if (dv_stat.done) begin
          state_next = pur_pkg::ST_RD0;
        end
      end
      pur_pkg::ST_RD0: begin
        mem_raddr  = AW'(1);
        state_next = pur_pkg::ST_RD1;
      end
      pur_pkg::ST_RD1:    state_next = pur_pkg::ST_SEEK;
      pur_pkg::ST_SEEK: begin
        mem_raddr = k + 1'b1;
        if (!at_last && cur.c < t) begin
          state_next = pur_pkg::ST_FETCH;
        end else begin
          state_next = pur_pkg::ST_MUL;
        end
      end
      pur_pkg::ST_FETCH:  state_next = pur_pkg::ST_SEEK;
      pur_pkg::ST_MUL: begin
        if (den == '0) begin
          if (j == 2'd2) begin
            state_next = pur_pkg::ST_EMIT;
          end
        end else begin
          state_next = pur_pkg::ST_DIVI;
        end
      end
      pur_pkg::ST_DIVI: begin
        // start the division once the product has landed in mul_p
        dv_start = !dv_stat.busy && !dv_stat.done && !dneg_go;
        if (dv_stat.done) begin
          state_next = (j == 2'd2) ? pur_pkg::ST_EMIT : pur_pkg::ST_MUL;
        end
      end
      pur_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = run_end ? pur_pkg::ST_LOAD : pur_pkg::ST_SEEK;
        end
      end
      default: state_next = pur_pkg::ST_LOAD;
    endcase
  end

  // marks that the division of this axis has been launched
  always_ff @(posedge clk) begin
    if (rst) begin
      dneg_go <= 1'b0;
    end else if (state == pur_pkg::ST_DIVI) begin
      dneg_go <= !dv_stat.done;
    end else begin
      dneg_go <= 1'b0;
    end
  end

  // vertex write into the memory
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = vcount[AW-1:0];
    mem_wdata = '{x: point_x, y: point_y, z: point_z, c: '0};
    if (state == pur_pkg::ST_LOAD && in_acc && vcount == '0) begin
      mem_we = 1'b1;
    end else if (state == pur_pkg::ST_ROOT && sq_stat.done) begin
      mem_we    = 1'b1;
      mem_wdata = '{x: lx, y: ly, z: lz, c: prev_c + LW'(sq_root)};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= NW'(1);
      vcount        <= '0;
    end else begin
      if (cfg_write_en) begin
        segment_count <= cfg_write_data;
      end
      if (mem_we) begin
        vcount <= vcount + 1'b1;
      end else if (state == pur_pkg::ST_EMIT && out_acc && run_end) begin
        vcount <= '0;
      end
    end
  end

  // load-side datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      lx  <= point_x;
      ly  <= point_y;
      lz  <= point_z;
      fin <= final_vertex;
    end
    if (mem_we) begin
      px     <= mem_wdata.x;
      py     <= mem_wdata.y;
      pz     <= mem_wdata.z;
      prev_c <= mem_wdata.c;
    end
    case (state)
      pur_pkg::ST_SQ1: acc <= {{(pur_pkg::RAD_W-pur_pkg::PROD_W){1'b0}}, mul_p};
      pur_pkg::ST_SQ2,
      pur_pkg::ST_SQ3: acc <= acc + {{(pur_pkg::RAD_W-pur_pkg::PROD_W){1'b0}}, mul_p};
      default: ;
    endcase
  end

  // output-side datapath
  always_ff @(posedge clk) begin
    case (state)
      pur_pkg::ST_FINAL: begin
        out_x          <= '0;
        out_y          <= '0;
        out_z          <= '0;
        run_end        <= 1'b1;
        too_few_points <= (vcount < CW'(2));
      end
      pur_pkg::ST_DIVL: begin
        step_q <= dv_quot[LW-1:0];
        step_r <= dv_rem[NW-1:0];
        t      <= '0;
        tr     <= '0;
        idx    <= '0;
      end
      pur_pkg::ST_RD0: prv <= mem_rdata;
      pur_pkg::ST_RD1: begin
        cur <= mem_rdata;
        k   <= AW'(1);
      end
      pur_pkg::ST_SEEK: begin
        if (!at_last && cur.c < t) begin
          prv <= cur;
          k   <= k + 1'b1;
        end else begin
          num <= SW'(t - prv.c);
          den <= SW'(cur.c - prv.c);
          j   <= 2'd0;
        end
      end
      pur_pkg::ST_FETCH: cur <= mem_rdata;
      pur_pkg::ST_MUL: begin
        dneg <= d[CL];
        if (den == '0) begin
          case (j)
            2'd0:    out_x <= pa;
            2'd1:    out_y <= pa;
            default: out_z <= pa;
          endcase
          j <= j + 1'b1;
          if (j == 2'd2) begin
            run_end        <= (idx == n_eff);
            too_few_points <= 1'b0;
          end
        end
      end
      pur_pkg::ST_DIVI: begin
        if (dv_stat.done) begin
          case (j)
            2'd0:    out_x <= dneg ? pa - dv_quot[CL-1:0] : pa + dv_quot[CL-1:0];
            2'd1:    out_y <= dneg ? pa - dv_quot[CL-1:0] : pa + dv_quot[CL-1:0];
            default: out_z <= dneg ? pa - dv_quot[CL-1:0] : pa + dv_quot[CL-1:0];
          endcase
          j <= j + 1'b1;
          if (j == 2'd2) begin
            run_end        <= (idx == n_eff);
            too_few_points <= 1'b0;
          end
        end
      end
      pur_pkg::ST_EMIT: begin
        // next target length: floor(i*L/n) kept as quotient and remainder
        if (out_acc && !run_end) begin
          idx <= idx + 1'b1;
          if (tr_sum >= {1'b0, n_eff}) begin
            t  <= t + step_q + 1'b1;
            tr <= tr_sum - {1'b0, n_eff};
          end else begin
            t  <= t + step_q;
            tr <= tr_sum;
          end
        end
      end
      default: ;
    endcase
  end

  // checks
  `PUR_NEVER(a_no_overlap, clk, rst, in_ready && out_valid)
  `PUR_ASSERT(a_err_beat, clk, rst, out_valid && too_few_points |-> run_end && out_x == '0)
  `PUR_ASSERT(a_run_done, clk, rst, out_valid && out_ready && run_end |=> in_ready && vcount == '0)
  `PUR_NEVER(a_count_range, clk, rst, vcount > CW'(MAX_VERTICES))

endmodule
`default_nettype wire
